[src/bitmap_id_allocator_top_macros.svh]
// Assertion macros shared by the allocator RTL.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef BITMAP_ID_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_ID_ALLOCATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge outside reset
`define BIA_HOLDS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("bia: invariant violated");

// Check that a condition implies another in the same cycle
`define BIA_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bia: implication violated");

// Check that a condition implies another in the following cycle
`define BIA_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bia: sequence violated");

`else

`define BIA_HOLDS(label, cond)
`define BIA_IMPLIES(label, ante, cons)
`define BIA_NEXT(label, ante, cons)

`endif

`endif

[src/bia_pkg.sv]
package bia_pkg;

  // Default geometry
  localparam int UNIT_BITS_DEF  = 64;
  localparam int UNIT_COUNT_DEF = 64;
  localparam int KEY_BITS_DEF   = 64;

  // Channel field widths
  localparam int ACTION_W      = 2;
  localparam int KEY_VALUE_W   = 64;
  localparam int TARGET_ID_W   = 12;
  localparam int STATUS_W      = 2;
  localparam int ASSIGNED_ID_W = 12;
  localparam int KEY_COUNT_W   = 13;

  // Fraction bits of the reciprocal used to split an id into unit and bit
  localparam int SPLIT_SHIFT = 20;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD      = 2'd0,
    ACT_UNSET    = 2'd1,
    ACT_TRUNCATE = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_UPDATE
  } state_t;

  // Index width for n entries, at least one bit
  function automatic int width_of(input int n);
    width_of = (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

[src/bia_ifs.sv]
interface bia_in_if;
  import bia_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ACTION_W-1:0]    action;
  logic [KEY_VALUE_W-1:0] key_value;
  logic [TARGET_ID_W-1:0] target_id;

  modport source(output valid, output action, output key_value, output target_id,
                 input ready);
  modport sink(input valid, input action, input key_value, input target_id,
               output ready);
endinterface

interface bia_out_if;
  import bia_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [ASSIGNED_ID_W-1:0] assigned_id;
  logic [KEY_COUNT_W-1:0]   key_count;

  modport source(output valid, output status, output assigned_id, output key_count,
                 input ready);
  modport sink(input valid, input status, input assigned_id, input key_count,
               output ready);
endinterface

[src/bia_id_split.sv]
module bia_id_split #(
  parameter int UNIT_BITS = bia_pkg::UNIT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            load,
  input  logic [bia_pkg::TARGET_ID_W-1:0] id,
  output logic [bia_pkg::TARGET_ID_W-1:0] quot,
  output logic [bia_pkg::width_of(UNIT_BITS)-1:0] rem
);
  import bia_pkg::*;

  localparam int BIT_W  = width_of(UNIT_BITS);
  localparam int RECIP  = (1 << SPLIT_SHIFT) / UNIT_BITS;
  localparam int PROD_W = TARGET_ID_W + SPLIT_SHIFT;

  logic [PROD_W-1:0]      prod;
  logic [TARGET_ID_W-1:0] id_r;
  logic [TARGET_ID_W-1:0] qest_r;
  logic [TARGET_ID_W-1:0] back;
  logic [TARGET_ID_W-1:0] rem_raw;

  // Estimate the quotient; it is exact or one short
  assign prod = PROD_W'(id) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      id_r   <= id;
      qest_r <= prod[PROD_W-1:SPLIT_SHIFT];
    end
  end

  // Correct the estimate with one compare and subtract
  assign back    = TARGET_ID_W'(qest_r * TARGET_ID_W'(UNIT_BITS));
  assign rem_raw = id_r - back;

  always_comb begin
    if (rem_raw >= TARGET_ID_W'(UNIT_BITS)) begin
      quot = qest_r + TARGET_ID_W'(1);
      rem  = BIT_W'(rem_raw - TARGET_ID_W'(UNIT_BITS));
    end else begin
      quot = qest_r;
      rem  = BIT_W'(rem_raw);
    end
  end

endmodule

[src/bia_ram.sv]
module bia_ram #(
  parameter int DEPTH = bia_pkg::UNIT_COUNT_DEF,
  parameter int WIDTH = bia_pkg::UNIT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [bia_pkg::width_of(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [bia_pkg::width_of(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);
  import bia_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/bia_key_store.sv]
module bia_key_store #(
  parameter int DEPTH = bia_pkg::UNIT_BITS_DEF * bia_pkg::UNIT_COUNT_DEF,
  parameter int WIDTH = bia_pkg::KEY_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [bia_pkg::width_of(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata
);
  import bia_pkg::*;

  logic [WIDTH-1:0] keys [DEPTH];

  // Store the key at its allocated id
  always_ff @(posedge clk) begin
    if (we) begin
      keys[waddr] <= wdata;
    end
  end

endmodule

[src/bitmap_id_allocator_top.sv]
// Bitmap id allocator with a linked list of units that have free ids.
// Input channel in_ch (valid/ready) carries action, key_value and target_id:
// add stores key_value at the lowest free id of the head unit (or of a fresh
// unit past the highest id), unset releases target_id, truncate empties the
// store. Every item gives exactly one result item on out_ch: status,
// assigned_id (zero unless an add succeeded) and key_count after the item.
// An item is accepted in S_IDLE, the unit memory is read in S_ADDR and
// written back in S_UPDATE, when the result is loaded into the output
// register; no new item is taken until that read-modify-write sequence on
// the unit memory is through and its result is loaded.
// While the result register is full and out_ch stalls, the block holds the
// finished update and the next item waits; once the result is taken the block
// goes idle and accepts again. Reset empties the free list and clears the
// highest id and the count; memories keep their contents and units are
// cleared as they are opened, so no clearing pass is needed.
`include "bitmap_id_allocator_top_macros.svh"

module bitmap_id_allocator_top #(
  parameter int UNIT_BITS  = bia_pkg::UNIT_BITS_DEF,
  parameter int UNIT_COUNT = bia_pkg::UNIT_COUNT_DEF,
  parameter int KEY_BITS   = bia_pkg::KEY_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  bia_in_if.sink           in_ch,
  bia_out_if.source        out_ch
);
  import bia_pkg::*;

  localparam int TOTAL_IDS = UNIT_BITS * UNIT_COUNT;
  localparam int BIT_W     = width_of(UNIT_BITS);
  localparam int UNIT_W    = width_of(UNIT_COUNT);
  localparam int FRESH_W   = $clog2(UNIT_COUNT + 1);
  localparam int ID_W      = width_of(TOTAL_IDS);
  localparam int HI_W      = $clog2(TOTAL_IDS + 1);
  localparam int CMP_W     = (HI_W > TARGET_ID_W) ? HI_W : TARGET_ID_W;
  localparam int LINK_W    = UNIT_W + 1;
  localparam int ENTRY_W   = UNIT_BITS + LINK_W;

  // Control state
  state_t              state_r, state_nxt;
  logic                head_valid_r, head_valid_nxt;
  logic [UNIT_W-1:0]   head_unit_r, head_unit_nxt;
  logic [FRESH_W-1:0]  fresh_r, fresh_nxt;
  logic [HI_W-1:0]     highest_r, highest_nxt;
  logic [HI_W-1:0]     used_r, used_nxt;
  logic                out_valid_r;

  // Item registers
  logic [ACTION_W-1:0] act_r;
  logic [KEY_BITS-1:0] key_r;
  logic                miss_r, miss_nxt;
  logic [UNIT_W-1:0]   unit_r, unit_sel;
  logic [BIT_W-1:0]    bit_r;
  logic [ID_W-1:0]     base_r, base_sel;
  logic                opening_r, opening_sel;

  // Result registers
  logic [STATUS_W-1:0]      out_status_r;
  logic [ASSIGNED_ID_W-1:0] out_id_r;
  logic [KEY_COUNT_W-1:0]   out_count_r;

  // Handshake and memory control
  logic in_fire;
  logic out_load;
  logic upd_fire;
  logic ram_re;

  // Id split
  logic [TARGET_ID_W-1:0] split_quot;
  logic [BIT_W-1:0]       split_rem;

  // Unit memory ports
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [UNIT_BITS-1:0] rd_occ;
  logic [LINK_W-1:0]    rd_link;

  // Update datapath
  logic [UNIT_BITS-1:0] word;
  logic [UNIT_BITS-1:0] new_word;
  logic [LINK_W-1:0]    link_in;
  logic [LINK_W-1:0]    new_link;
  logic [BIT_W-1:0]     free_bit;
  logic                 has_free;
  logic [ID_W-1:0]      new_id;
  logic [UNIT_BITS-1:0] bit_mask;
  logic                 key_we;
  status_t              status_nxt;
  logic [ASSIGNED_ID_W-1:0] id_nxt;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_load = !out_valid_r || out_ch.ready;

  bia_id_split #(
    .UNIT_BITS(UNIT_BITS)
  ) u_split (
    .clk  (clk),
    .load (in_fire),
    .id   (in_ch.target_id),
    .quot (split_quot),
    .rem  (split_rem)
  );

  bia_ram #(
    .DEPTH(UNIT_COUNT),
    .WIDTH(ENTRY_W)
  ) u_unit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (unit_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (unit_sel),
    .rdata (ram_rdata)
  );

  bia_key_store #(
    .DEPTH(TOTAL_IDS),
    .WIDTH(KEY_BITS)
  ) u_keys (
    .clk   (clk),
    .we    (key_we),
    .waddr (new_id),
    .wdata (key_r)
  );

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_ADDR;
      S_ADDR:   state_nxt = S_UPDATE;
      S_UPDATE: if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Drive sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    ram_re      = 1'b0;
    upd_fire    = 1'b0;
    case (state_r)
      S_IDLE:   in_ch.ready = 1'b1;
      S_ADDR:   ram_re = !miss_r && !opening_sel;
      S_UPDATE: upd_fire = out_load;
      default:  in_ch.ready = 1'b0;
    endcase
  end

  // Flag a full store or an id past the highest at acceptance
  always_comb begin
    case (action_t'(in_ch.action))
      ACT_ADD:   miss_nxt = !head_valid_r && (fresh_r >= FRESH_W'(UNIT_COUNT));
      ACT_UNSET: miss_nxt = (CMP_W'(in_ch.target_id) >= CMP_W'(highest_r)) ||
                            (CMP_W'(in_ch.target_id) >= CMP_W'(TOTAL_IDS));
      default:   miss_nxt = 1'b0;
    endcase
  end

  // Pick the unit to read: head, fresh unit or the unit of the released id
  always_comb begin
    if (action_t'(act_r) == ACT_UNSET) begin
      unit_sel    = UNIT_W'(split_quot);
      opening_sel = 1'b0;
    end else begin
      unit_sel    = head_valid_r ? head_unit_r : UNIT_W'(fresh_r);
      opening_sel = (action_t'(act_r) == ACT_ADD) && !head_valid_r;
    end
    base_sel = ID_W'(unit_sel * UNIT_BITS);
  end

  assign rd_occ  = ram_rdata[UNIT_BITS-1:0];
  assign rd_link = ram_rdata[ENTRY_W-1:UNIT_BITS];

  // Find the lowest clear bit of the unit
  assign word = opening_r ? '0 : rd_occ;

  always_comb begin
    free_bit = '0;
    has_free = 1'b0;
    for (int i = UNIT_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        free_bit = BIT_W'(i);
        has_free = 1'b1;
      end
    end
  end

  assign link_in  = opening_r ? '0 : rd_link;
  assign new_id   = base_r + ID_W'(free_bit);
  assign bit_mask = UNIT_BITS'(1) << bit_r;

  // Modify the unit and the list head
  always_comb begin
    head_valid_nxt = head_valid_r;
    head_unit_nxt  = head_unit_r;
    fresh_nxt      = fresh_r;
    highest_nxt    = highest_r;
    used_nxt       = used_r;
    new_word       = word;
    new_link       = link_in;
    ram_we         = 1'b0;
    key_we         = 1'b0;
    status_nxt     = STAT_OK;
    id_nxt         = '0;
    case (action_t'(act_r))
      ACT_ADD: begin
        if (miss_r || !has_free) begin
          status_nxt = STAT_FULL;
        end else begin
          new_word = word | (UNIT_BITS'(1) << free_bit);
          ram_we   = upd_fire;
          key_we   = upd_fire;
          id_nxt   = ASSIGNED_ID_W'(new_id);
          used_nxt = used_r + HI_W'(1);
          if (opening_r) begin
            fresh_nxt = fresh_r + FRESH_W'(1);
          end
          if (&new_word) begin
            head_valid_nxt = link_in[LINK_W-1];
            head_unit_nxt  = link_in[UNIT_W-1:0];
          end else begin
            head_valid_nxt = 1'b1;
            head_unit_nxt  = unit_r;
          end
          if (HI_W'(new_id) + HI_W'(1) > highest_r) begin
            highest_nxt = HI_W'(new_id) + HI_W'(1);
          end
        end
      end
      ACT_UNSET: begin
        if (miss_r || ((rd_occ & bit_mask) == '0)) begin
          status_nxt = STAT_NOT_FOUND;
        end else begin
          new_word = rd_occ & ~bit_mask;
          ram_we   = upd_fire;
          if (&rd_occ) begin
            new_link       = {head_valid_r, head_unit_r};
            head_valid_nxt = 1'b1;
            head_unit_nxt  = unit_r;
          end
          if (used_r != '0) begin
            used_nxt = used_r - HI_W'(1);
          end
        end
      end
      ACT_TRUNCATE: begin
        head_valid_nxt = 1'b0;
        head_unit_nxt  = '1;
        fresh_nxt      = '0;
        highest_nxt    = '0;
        used_nxt       = '0;
      end
      default: status_nxt = STAT_OK;
    endcase
  end

  assign ram_wdata = {new_link, new_word};

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_valid_r <= 1'b0;
      head_unit_r  <= '1;
      fresh_r      <= '0;
      highest_r    <= '0;
      used_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_fire) begin
        head_valid_r <= head_valid_nxt;
        head_unit_r  <= head_unit_nxt;
        fresh_r      <= fresh_nxt;
        highest_r    <= highest_nxt;
        used_r       <= used_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= in_ch.action;
      key_r  <= in_ch.key_value[KEY_BITS-1:0];
      miss_r <= miss_nxt;
    end
    if (state_r == S_ADDR) begin
      unit_r    <= unit_sel;
      bit_r     <= split_rem;
      base_r    <= base_sel;
      opening_r <= opening_sel;
    end
    if (upd_fire) begin
      out_status_r <= status_nxt;
      out_id_r     <= id_nxt;
      out_count_r  <= KEY_COUNT_W'(used_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.assigned_id = out_id_r;
  assign out_ch.key_count   = out_count_r;

  `BIA_HOLDS(a_used_within_high, used_r <= highest_r)
  `BIA_IMPLIES(a_head_is_opened, head_valid_r, FRESH_W'(head_unit_r) < fresh_r)
  `BIA_IMPLIES(a_no_head_all_full, !head_valid_r, highest_r == HI_W'(fresh_r * UNIT_BITS))
  `BIA_NEXT(a_update_delivers, upd_fire, (state_r == S_IDLE) && out_valid_r)

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  import bia_pkg::*;

  localparam int UNIT_W   = UNIT_BITS_DEF;
  localparam int UNITS    = UNIT_COUNT_DEF;
  localparam int ID_SPACE = UNIT_W * UNITS;

  // Tracks allocator state and the replies that accepted requests must produce
  class id_alloc_tracker;
    typedef struct {
      status_t                  status;
      logic [ASSIGNED_ID_W-1:0] id;
      logic [KEY_COUNT_W-1:0]   count;
    } reply_t;

    bit [UNIT_W-1:0] unit_map [UNITS];
    int              link_unit [UNITS];
    bit              link_ok [UNITS];
    int              head_unit;
    bit              head_ok;
    int              id_limit;
    int              live;
    reply_t          replies [$];
    int              errors;

    function new();
      head_unit = 0;
      head_ok   = 0;
      id_limit  = 0;
      live      = 0;
      errors    = 0;
    endfunction

    function int pending();
      return replies.size();
    endfunction

    // Apply one accepted request and queue the reply it must give
    function void take_request(action_t act, logic [TARGET_ID_W-1:0] tgt);
      reply_t r;
      int     u;
      int     b;
      r.status = STAT_OK;
      r.id     = '0;
      case (act)
        ACT_ADD: begin
          if (!head_ok && id_limit / UNIT_W >= UNITS) begin
            r.status = STAT_FULL;
          end else begin
            // open a fresh unit past the highest id when the list is empty
            if (!head_ok) begin
              u = id_limit / UNIT_W;
              unit_map[u]  = '0;
              link_ok[u]   = 0;
              link_unit[u] = 0;
              head_unit    = u;
              head_ok      = 1;
            end else begin
              u = head_unit;
            end
            b = 0;
            while (b < UNIT_W && unit_map[u][b]) b++;
            if (b == UNIT_W) begin
              r.status = STAT_FULL;
            end else begin
              unit_map[u][b] = 1'b1;
              // unlink a unit that just became full
              if (&unit_map[u]) begin
                head_ok   = link_ok[u];
                head_unit = link_unit[u];
              end
              r.id = ASSIGNED_ID_W'(u * UNIT_W + b);
              if (u * UNIT_W + b + 1 > id_limit) id_limit = u * UNIT_W + b + 1;
              live++;
            end
          end
        end
        ACT_UNSET: begin
          u = tgt / UNIT_W;
          b = tgt % UNIT_W;
          if (tgt >= id_limit || !unit_map[u][b]) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            // a full unit regains a free id: push it as the new head
            if (&unit_map[u]) begin
              link_unit[u] = head_unit;
              link_ok[u]   = head_ok;
              head_unit    = u;
              head_ok      = 1;
            end
            unit_map[u][b] = 1'b0;
            if (live > 0) live--;
          end
        end
        ACT_TRUNCATE: begin
          id_limit  = 0;
          live      = 0;
          head_ok   = 0;
          head_unit = 0;
        end
        default: ;
      endcase
      r.count = KEY_COUNT_W'(live);
      replies.push_back(r);
    endfunction

    // Compare one result item with the oldest queued reply
    function void match_response(logic [STATUS_W-1:0] st, logic [ASSIGNED_ID_W-1:0] id,
                                 logic [KEY_COUNT_W-1:0] cnt);
      reply_t r;
      if (replies.size() == 0) begin
        $error("unexpected result item: status %0d, assigned_id %0d, key_count %0d",
               st, id, cnt);
        errors++;
        return;
      end
      r = replies.pop_front();
      if (st !== r.status) begin
        $error("status mismatch: expected %0d, got %0d", r.status, st);
        errors++;
      end
      if (id !== r.id) begin
        $error("assigned_id mismatch: expected %0d, got %0d", r.id, id);
        errors++;
      end
      if (cnt !== r.count) begin
        $error("key_count mismatch: expected %0d, got %0d", r.count, cnt);
        errors++;
      end
    endfunction

    // Mostly release live ids; sometimes clear or out-of-range ones
    function logic [TARGET_ID_W-1:0] pick_target();
      int r;
      int cand;
      r    = $urandom_range(99);
      cand = 0;
      if (id_limit == 0 || r >= 90) return TARGET_ID_W'($urandom_range(ID_SPACE - 1));
      if (r >= 75) return TARGET_ID_W'($urandom_range(id_limit - 1));
      repeat (16) begin
        cand = $urandom_range(id_limit - 1);
        if (unit_map[cand / UNIT_W][cand % UNIT_W]) return TARGET_ID_W'(cand);
      end
      return TARGET_ID_W'(cand);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   in_idle_pct;
  int   out_stall_pct;
  int   hold_off_left;
  int   random_sent;

  id_alloc_tracker tracker = new();

  bia_in_if  in_ch ();
  bia_out_if out_ch ();

  bitmap_id_allocator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fail the run if it hangs
  initial begin
    #5000000;
    $display("** bitmap_id_allocator_top: FAILED **");
    $finish;
  end

  // Result side: stall at random, or hold off for a counted stretch
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ch.ready = 1'b0;
        hold_off_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // Check every result item taken at a rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.match_response(out_ch.status, out_ch.assigned_id, out_ch.key_count);
  end

  function automatic logic [KEY_VALUE_W-1:0] random_key();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Offer one item, idling first at random, and note it once accepted
  task automatic send_item(action_t act, logic [KEY_VALUE_W-1:0] key,
                           logic [TARGET_ID_W-1:0] tgt);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.action    = act;
    in_ch.key_value = key;
    in_ch.target_id = tgt;
    do @(posedge clk); while (!in_ch.ready);
    tracker.take_request(act, tgt);
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Alternate between growing and shrinking the population
  task automatic send_random_item();
    int  r;
    bit  growing;
    growing = ((random_sent / 150) % 2) == 0;
    r = $urandom_range(999);
    random_sent++;
    if (r < 3)
      send_item(ACT_TRUNCATE, random_key(), TARGET_ID_W'($urandom_range(ID_SPACE - 1)));
    else if (r < (growing ? 660 : 310))
      send_item(ACT_ADD, random_key(), TARGET_ID_W'($urandom_range(ID_SPACE - 1)));
    else
      send_item(ACT_UNSET, random_key(), tracker.pick_target());
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    repeat (count) send_random_item();
    drain();
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_ADD;
    in_ch.key_value = '0;
    in_ch.target_id = '0;
    rst_n           = 1'b0;
    in_idle_pct     = 0;
    out_stall_pct   = 0;
    hold_off_left   = 0;
    random_sent     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty store, reuse of lowest bit, past-highest and clear-bit unsets
    send_item(ACT_UNSET, '0, '0);
    send_item(ACT_ADD, '0, '1);
    send_item(ACT_ADD, '1, '0);
    send_item(ACT_UNSET, '1, 12'd1);
    send_item(ACT_UNSET, '0, 12'd1);
    send_item(ACT_ADD, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    send_item(ACT_UNSET, '0, '1);
    send_item(ACT_UNSET, '0, 12'd2);
    send_item(ACT_TRUNCATE, '1, '1);
    send_item(ACT_UNSET, '0, '0);
    send_item(ACT_ADD, 64'h5555_5555_5555_5555, '0);
    send_item(ACT_ADD, random_key(), '0);
    send_item(ACT_ADD, random_key(), '1);
    send_item(ACT_UNSET, '0, '0);
    send_item(ACT_ADD, random_key(), '0);
    send_item(ACT_TRUNCATE, '0, '0);
    drain();

    // Fill three units, then push a full unit back onto the free-unit list
    in_idle_pct   = 8;
    out_stall_pct = 8;
    repeat (3 * UNIT_W)
      send_item(ACT_ADD, random_key(), TARGET_ID_W'($urandom_range(ID_SPACE - 1)));
    send_item(ACT_ADD, random_key(), '0);
    send_item(ACT_ADD, random_key(), '1);
    send_item(ACT_UNSET, '0, TARGET_ID_W'(ID_SPACE - 1));
    send_item(ACT_UNSET, '0, TARGET_ID_W'(UNIT_W + 6));
    send_item(ACT_UNSET, '0, TARGET_ID_W'(UNIT_W + 7));
    send_item(ACT_ADD, random_key(), '0);
    send_item(ACT_ADD, random_key(), '0);
    send_item(ACT_ADD, random_key(), '0);
    send_item(ACT_ADD, random_key(), '0);
    send_item(ACT_UNSET, '0, TARGET_ID_W'(ID_SPACE - 1));
    send_item(ACT_TRUNCATE, '0, '0);
    drain();

    // Random phases across idling patterns
    run_phase(0, 0, 240);

    // Hold off the result side long enough to back up the input
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_off_left = 200;
    repeat (12) send_random_item();
    drain();

    run_phase(66, 0, 240);
    run_phase(0, 66, 240);
    run_phase(8, 8, 240);

    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("** bitmap_id_allocator_top: PASSED **");
    else
      $display("** bitmap_id_allocator_top: FAILED **");
    $finish;
  end

endmodule
